// ===== design/rspw_pkg.sv =====
// Shared types, widths and constants for the RAID stripe parity writer.
// No dependencies; every other file but rspw_ram imports this package.
package rspw_pkg;

    // Field widths
    localparam int DATA_W      = 8;
    localparam int BLK_W       = 24;
    localparam int SIZE_W      = 13;
    localparam int HOST_W      = 4;
    localparam int LEVEL_W     = 2;
    localparam int COUNT_W     = 25;
    localparam int CFG_W       = 25;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_HOST_W  = 3;
    localparam int OUT_OFS_W   = 12;

    // Defaults for the top-level parameters
    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int HOSTS_MAX_DEF   = 8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAID_LEVEL  = 2'd0,
        CFG_NUM_HOSTS   = 2'd1,
        CFG_BLOCK_SIZE  = 2'd2,
        CFG_BLOCK_COUNT = 2'd3
    } cfg_idx_t;

    // Layout codes
    localparam logic [LEVEL_W-1:0] LEVEL_STRIPE = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_FIXED  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_ROTATE = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_UNUSED = 2'd3;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RAID_LEVEL_RST  = LEVEL_FIXED;
    localparam logic [HOST_W-1:0]  NUM_HOSTS_RST   = 4'd4;
    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 13'd4096;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 25'd16777216;

    // One classified byte, as passed from front to back
    typedef struct packed {
        logic               err;
        logic [HOST_W-1:0]  host;
        logic [SIZE_W-1:0]  ofs;
        logic [DATA_W-1:0]  data;
        logic [DATA_W-1:0]  pval;
        logic [HOST_W-1:0]  phost;
        logic               pfinal;
        logic               last;
    } entry_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [BLK_W-1:0]   dividend;
        logic [HOST_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [BLK_W-1:0]   quo;
        logic [HOST_W-1:0]  rem;
    } div_rsp_t;

endpackage

// ===== design/rspw_item_if.sv =====
// Input channel of the stripe parity writer: one data byte and its block number.
// Depends on rspw_pkg for field widths.
interface rspw_item_if
    import rspw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic [BLK_W-1:0]  block_number;

    modport source (output valid, output data_byte, output block_number, input ready);
    modport sink   (input valid, input data_byte, input block_number, output ready);
endinterface

// ===== design/rspw_result_if.sv =====
// Output channel of the stripe parity writer: one routed data or parity byte.
// Depends on rspw_pkg for field widths.
interface rspw_result_if
    import rspw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OUT_HOST_W-1:0] host_index;
    logic [OUT_OFS_W-1:0]  stripe_offset;
    logic [DATA_W-1:0]     out_byte;
    logic                  is_parity;
    logic                  block_done;
    logic                  last_of_item;
    logic                  status;

    modport source (output valid, output host_index, output stripe_offset, output out_byte,
                    output is_parity, output block_done, output last_of_item,
                    output status, input ready);
    modport sink   (input valid, input host_index, input stripe_offset, input out_byte,
                    input is_parity, input block_done, input last_of_item,
                    input status, output ready);
endinterface

// ===== design/rspw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rspw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/rspw_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, narrow divisor.
// Depends on rspw_pkg for widths and the request/response structs.
module rspw_div
    import rspw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CNT_W = $clog2(BLK_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [BLK_W-1:0]  quo_reg;
    logic [HOST_W-1:0] rem_reg;
    logic [HOST_W-1:0] div_reg;

    logic [HOST_W:0]   shifted;
    logic              fits;
    logic [HOST_W:0]   diff;

    // One restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[BLK_W-1]};
        fits    = (shifted >= {1'b0, div_reg});
        diff    = shifted - {1'b0, div_reg};
    end

    // Load on start, step while busy, pulse done after the last step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(BLK_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[BLK_W-2:0], fits};
            rem_reg <= fits ? diff[HOST_W-1:0] : shifted[HOST_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;
endmodule

// ===== design/rspw_front.sv =====
// Front part: configuration registers, block position tracking, parity store
// read-modify-write and classification of each byte. Uses rspw_pkg, rspw_ram,
// rspw_div and the input channel interface.
module rspw_front
    import rspw_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int HOSTS_MAX   = HOSTS_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    rspw_item_if.sink            item,
    output logic                 q_push,
    output entry_t               q_entry,
    input  logic                 q_full
);
    localparam int AW = $clog2(BLOCK_BYTES);

    typedef enum logic [2:0] {
        F_SETUP,
        F_SETUP_WAIT,
        F_IDLE,
        F_MOD_WAIT,
        F_EXEC
    } fstate_t;

    fstate_t            state_reg;
    logic [LEVEL_W-1:0] raid_level_reg;
    logic [HOST_W-1:0]  num_hosts_reg;
    logic [SIZE_W-1:0]  block_size_reg;
    logic [COUNT_W-1:0] block_count_reg;
    logic [SIZE_W-1:0]  pos_reg;
    logic [HOST_W-1:0]  stripe_reg;
    logic [SIZE_W-1:0]  ofs_reg;
    logic [HOST_W-1:0]  phost_reg;
    logic [SIZE_W-1:0]  q_reg;
    logic [HOST_W-1:0]  e_reg;
    logic [DATA_W-1:0]  byte_reg;

    logic [LEVEL_W-1:0] level;
    logic               with_parity;
    logic [HOST_W-1:0]  n_eff;
    logic [HOST_W-1:0]  s_eff;
    logic [SIZE_W-1:0]  size_eff;
    logic               accept;
    logic               out_of_range;
    logic [HOST_W-1:0]  host_sel;
    logic               last_byte;
    logic               pfinal;
    logic [DATA_W-1:0]  pval;
    logic [SIZE_W:0]    stripe_len;
    logic               stripe_end;
    logic [DATA_W-1:0]  rdata;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Effective layout, host count and block size
    always_comb
    begin
        level       = (raid_level_reg == LEVEL_UNUSED) ? LEVEL_STRIPE : raid_level_reg;
        with_parity = (level != LEVEL_STRIPE);
        if (num_hosts_reg < HOST_W'(2))
        begin
            n_eff = HOST_W'(2);
        end
        else if (num_hosts_reg > HOSTS_MAX)
        begin
            n_eff = HOST_W'(HOSTS_MAX);
        end
        else
        begin
            n_eff = num_hosts_reg;
        end
        s_eff = with_parity ? n_eff - 1'b1 : n_eff;
        if (block_size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (block_size_reg > BLOCK_BYTES)
        begin
            size_eff = SIZE_W'(BLOCK_BYTES);
        end
        else
        begin
            size_eff = block_size_reg;
        end
    end

    // Input handshake and range check
    assign item.ready   = (state_reg == F_IDLE) && !q_full;
    assign accept       = item.valid && item.ready;
    assign out_of_range = ({1'b0, item.block_number} >= block_count_reg);

    // Classify the byte held for execution
    always_comb
    begin
        host_sel = stripe_reg;
        if ((level == LEVEL_ROTATE) && (stripe_reg >= phost_reg))
        begin
            host_sel = stripe_reg + 1'b1;
        end
        last_byte  = ((SIZE_W+1)'(pos_reg) + 1'b1) >= (SIZE_W+1)'(size_eff);
        pfinal     = with_parity &&
                     ((stripe_reg == s_eff - 1'b1) ||
                      ((e_reg != '0) && (ofs_reg == q_reg) && (stripe_reg == e_reg - 1'b1)));
        pval       = (stripe_reg == '0) ? byte_reg : (rdata ^ byte_reg);
        stripe_len = (SIZE_W+1)'(q_reg) + (SIZE_W+1)'(stripe_reg < e_reg);
        stripe_end = ((SIZE_W+1)'(ofs_reg) + 1'b1) >= stripe_len;
    end

    // Divider: quotient and remainder of the block size at setup,
    // block number mod hosts at the first byte of a rotating-parity block
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = BLK_W'(size_eff);
        div_req.divisor  = s_eff;
        if (state_reg == F_SETUP)
        begin
            div_req.start = 1'b1;
        end
        else if (accept && !out_of_range && (pos_reg == '0) && (level == LEVEL_ROTATE))
        begin
            div_req.start    = 1'b1;
            div_req.dividend = item.block_number;
            div_req.divisor  = n_eff;
        end
    end

    rspw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Parity store: read at the current offset, write the running XOR
    rspw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BLOCK_BYTES)
    ) u_store (
        .clk   (clk),
        .we    ((state_reg == F_EXEC) && with_parity),
        .waddr (AW'(ofs_reg)),
        .wdata (pval),
        .raddr (AW'(ofs_reg)),
        .rdata (rdata)
    );

    // Push error entries at transfer, data entries at execution
    always_comb
    begin
        q_push         = 1'b0;
        q_entry.err    = 1'b0;
        q_entry.host   = host_sel;
        q_entry.ofs    = ofs_reg;
        q_entry.data   = byte_reg;
        q_entry.pval   = pval;
        q_entry.phost  = phost_reg;
        q_entry.pfinal = pfinal;
        q_entry.last   = last_byte;
        if (state_reg == F_EXEC)
        begin
            q_push = 1'b1;
        end
        else if (accept && out_of_range)
        begin
            q_push      = 1'b1;
            q_entry.err = 1'b1;
        end
    end

    // Sequencer, configuration and block position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= F_SETUP;
            raid_level_reg  <= RAID_LEVEL_RST;
            num_hosts_reg   <= NUM_HOSTS_RST;
            block_size_reg  <= BLOCK_SIZE_RST;
            block_count_reg <= BLOCK_COUNT_RST;
            pos_reg         <= '0;
            stripe_reg      <= '0;
            ofs_reg         <= '0;
            phost_reg       <= '0;
            q_reg           <= '0;
            e_reg           <= '0;
            byte_reg        <= '0;
        end
        else if (cfg_we)
        begin
            // Any register write abandons the block and reruns setup
            case (cfg_idx_t'(cfg_index))
                CFG_RAID_LEVEL:  raid_level_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_NUM_HOSTS:   num_hosts_reg   <= cfg_data[HOST_W-1:0];
                CFG_BLOCK_SIZE:  block_size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
            pos_reg    <= '0;
            stripe_reg <= '0;
            ofs_reg    <= '0;
            state_reg  <= F_SETUP;
        end
        else
        begin
            case (state_reg)
                F_SETUP:
                begin
                    state_reg <= F_SETUP_WAIT;
                end
                F_SETUP_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        q_reg     <= div_rsp.quo[SIZE_W-1:0];
                        e_reg     <= div_rsp.rem;
                        state_reg <= F_IDLE;
                    end
                end
                F_IDLE:
                begin
                    if (accept && !out_of_range)
                    begin
                        byte_reg  <= item.data_byte;
                        state_reg <= F_EXEC;
                        if (pos_reg == '0)
                        begin
                            if (level == LEVEL_ROTATE)
                            begin
                                state_reg <= F_MOD_WAIT;
                            end
                            else if (level == LEVEL_FIXED)
                            begin
                                phost_reg <= n_eff - 1'b1;
                            end
                            else
                            begin
                                phost_reg <= '0;
                            end
                        end
                    end
                end
                F_MOD_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        phost_reg <= div_rsp.rem;
                        state_reg <= F_EXEC;
                    end
                end
                F_EXEC:
                begin
                    // Advance position, stripe and offset
                    if (last_byte)
                    begin
                        pos_reg    <= '0;
                        stripe_reg <= '0;
                        ofs_reg    <= '0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (stripe_end)
                        begin
                            stripe_reg <= stripe_reg + 1'b1;
                            ofs_reg    <= '0;
                        end
                        else
                        begin
                            ofs_reg <= ofs_reg + 1'b1;
                        end
                    end
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_SETUP;
                end
            endcase
        end
    end
endmodule

// ===== design/rspw_queue.sv =====
// Short register queue of classified entries between front and back.
// Depends on rspw_pkg for the entry type and default depth.
module rspw_queue
    import rspw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ===== design/rspw_back.sv =====
// Back part: expands each queued entry into its data and parity results and
// holds them in the output register. Uses rspw_pkg and the result interface.
module rspw_back
    import rspw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  entry_t       head,
    input  logic         empty,
    output logic         pop,
    rspw_result_if.source result
);
    logic                  valid_reg;
    logic                  phase_reg;
    logic [OUT_HOST_W-1:0] host_reg;
    logic [OUT_OFS_W-1:0]  ofs_reg;
    logic [DATA_W-1:0]     byte_reg;
    logic                  parity_reg;
    logic                  done_reg;
    logic                  last_reg;
    logic                  status_reg;
    logic                  load;

    // Load a result when the output register is free or being taken
    assign load = !empty && (!valid_reg || result.ready);
    assign pop  = load && (phase_reg || head.err || !head.pfinal);

    // Control: valid and parity phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= !phase_reg && !head.err && head.pfinal;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (head.err)
            begin
                host_reg   <= '0;
                ofs_reg    <= '0;
                byte_reg   <= '0;
                parity_reg <= 1'b0;
                done_reg   <= 1'b0;
                last_reg   <= 1'b1;
                status_reg <= 1'b1;
            end
            else if (phase_reg)
            begin
                host_reg   <= head.phost[OUT_HOST_W-1:0];
                ofs_reg    <= head.ofs[OUT_OFS_W-1:0];
                byte_reg   <= head.pval;
                parity_reg <= 1'b1;
                done_reg   <= head.last;
                last_reg   <= 1'b1;
                status_reg <= 1'b0;
            end
            else
            begin
                host_reg   <= head.host[OUT_HOST_W-1:0];
                ofs_reg    <= head.ofs[OUT_OFS_W-1:0];
                byte_reg   <= head.data;
                parity_reg <= 1'b0;
                done_reg   <= !head.pfinal && head.last;
                last_reg   <= !head.pfinal;
                status_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = valid_reg;
    assign result.host_index    = host_reg;
    assign result.stripe_offset = ofs_reg;
    assign result.out_byte      = byte_reg;
    assign result.is_parity     = parity_reg;
    assign result.block_done    = done_reg;
    assign result.last_of_item  = last_reg;
    assign result.status        = status_reg;
endmodule

// ===== design/raid_stripe_parity_writer.sv =====
// Streaming RAID 0/4/5 write path: bytes of a block come in one per transfer
// and leave as routed data bytes plus finished XOR parity bytes. A byte is
// accepted in F_IDLE, then does its parity store read-modify-write in F_EXEC,
// and the front takes no new byte before F_EXEC is done; a byte whose block
// number is out of range is pushed as an error entry straight from F_IDLE.
// The first byte of a block in rotating-parity mode also waits in F_MOD_WAIT
// while the shared one-bit-per-cycle divider works out the block number
// modulo the host count. After reset and after every register write the same
// divider computes the stripe length from block size and stripe count, and
// the input is not ready until it is done. A byte that finishes a parity
// offset produces two results, which leave the output register one after the
// other while the queue lets the front go on. The parity store is not
// cleared: stripe 0 writes every offset before later stripes read it.
// Top level; depends on rspw_pkg, both channel interfaces, rspw_front,
// rspw_queue and rspw_back.
module raid_stripe_parity_writer
    import rspw_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int HOSTS_MAX   = HOSTS_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    rspw_item_if.sink            item,
    rspw_result_if.source        result
);
    logic   q_push;
    entry_t q_entry;
    logic   q_full;
    logic   q_pop;
    entry_t q_head;
    logic   q_empty;

    // Accept and classify bytes
    rspw_front #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .HOSTS_MAX   (HOSTS_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .q_full    (q_full)
    );

    // Decouple front and back
    rspw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    // Emit data and parity results
    rspw_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .empty  (q_empty),
        .pop    (q_pop),
        .result (result)
    );
endmodule

// ===== sim/raid_stripe_parity_writer_test.sv =====
`timescale 1ns / 1ps
// Testbench for raid_stripe_parity_writer: directed layout tests and random block traffic,
// each transfer checked against a built-in routing and XOR parity predictor.
// Depends on rspw_pkg, rspw_item_if, rspw_result_if and the block itself.
module raid_stripe_parity_writer_test;
    import rspw_pkg::*;

    localparam int          STALL_NONE   = 0;
    localparam int          STALL_LIGHT  = 1;
    localparam int          STALL_HEAVY  = 2;
    localparam int unsigned BLOCKS_ALL   = 25'h1000000;
    localparam int unsigned BLK_MAX      = 24'hFFFFFF;
    localparam int          SETTLE_CYC   = 32;
    localparam int          TAIL_CYC     = 40;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          BIG_HEAD     = 16;

    typedef struct packed {
        logic [OUT_HOST_W-1:0] host;
        logic [OUT_OFS_W-1:0]  ofs;
        logic [DATA_W-1:0]     data;
        logic                  parity;
        logic                  done;
        logic                  last;
        logic                  status;
    } routed_byte_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rspw_item_if   item_ch ();
    rspw_result_if res_ch ();

    raid_stripe_parity_writer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    // Predictor copy of the registers and the write-path state
    logic [LEVEL_W-1:0]   cur_level  = RAID_LEVEL_RST;
    logic [HOST_W-1:0]    cur_hosts  = NUM_HOSTS_RST;
    logic [SIZE_W-1:0]    cur_size   = BLOCK_SIZE_RST;
    logic [COUNT_W-1:0]   cur_count  = BLOCK_COUNT_RST;
    logic [OUT_OFS_W-1:0] byte_pos   = '0;
    logic [OUT_HOST_W-1:0] cur_stripe = '0;
    logic [OUT_OFS_W-1:0] stripe_ofs = '0;
    logic [OUT_HOST_W-1:0] par_host  = '0;
    logic [DATA_W-1:0]    xor_store [0:BLOCK_BYTES_DEF-1];

    routed_byte_t expected_routes [$];

    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned reg_writes     = 0;
    int unsigned random_items   = 0;
    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Give up well past the slowest legal run
    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned clamped_hosts();
        if (cur_hosts < 2)
            return 2;
        if (cur_hosts > HOSTS_MAX_DEF)
            return HOSTS_MAX_DEF;
        return cur_hosts;
    endfunction

    function automatic int unsigned clamped_size();
        if (cur_size == 0)
            return 1;
        if (cur_size > BLOCK_BYTES_DEF)
            return BLOCK_BYTES_DEF;
        return cur_size;
    endfunction

    function automatic void restart_block();
        byte_pos   = '0;
        cur_stripe = '0;
        stripe_ofs = '0;
    endfunction

    // Route one accepted byte and queue the data and parity results it causes
    function automatic void route_byte(input logic [DATA_W-1:0] din,
                                       input logic [BLK_W-1:0] blk);
        int unsigned        n, size, s, q, e, d, o, len;
        logic [LEVEL_W-1:0] lvl;
        logic               with_par, last_b, fin;
        logic [DATA_W-1:0]  pv;
        routed_byte_t       r;
        r = '0;
        // Drop out-of-range bytes with an error result, state untouched
        if (blk >= cur_count) begin
            r.last   = 1'b1;
            r.status = 1'b1;
            expected_routes.push_back(r);
            return;
        end
        n        = clamped_hosts();
        size     = clamped_size();
        lvl      = (cur_level == LEVEL_UNUSED) ? LEVEL_STRIPE : cur_level;
        with_par = (lvl != LEVEL_STRIPE);
        s        = with_par ? n - 1 : n;
        q        = size / s;
        e        = size % s;
        // Latch the parity host on the first byte of a block
        if (byte_pos == 0) begin
            if (lvl == LEVEL_ROTATE)
                par_host = OUT_HOST_W'(blk % n);
            else if (lvl == LEVEL_FIXED)
                par_host = OUT_HOST_W'(n - 1);
            else
                par_host = '0;
        end
        d      = cur_stripe;
        o      = stripe_ofs;
        r.host = OUT_HOST_W'(((lvl == LEVEL_ROTATE) && (d >= par_host)) ? d + 1 : d);
        last_b = (byte_pos + 1 >= size);
        fin    = 1'b0;
        pv     = din;
        // Accumulate parity per offset; finish it on the last stripe that feeds it
        if (with_par) begin
            if (d != 0)
                pv = xor_store[o] ^ din;
            xor_store[o] = pv;
            fin = (d == s - 1) || (e > 0 && o == q && d == e - 1);
        end
        r.ofs  = OUT_OFS_W'(o);
        r.data = din;
        r.done = !fin && last_b;
        r.last = !fin;
        expected_routes.push_back(r);
        if (fin) begin
            r.host   = par_host;
            r.data   = pv;
            r.parity = 1'b1;
            r.done   = last_b;
            r.last   = 1'b1;
            expected_routes.push_back(r);
        end
        // Advance position, stripe and offset
        if (last_b) begin
            restart_block();
        end
        else begin
            byte_pos = byte_pos + 1'b1;
            len = q + ((d < e) ? 1 : 0);
            if (o + 1 >= len) begin
                cur_stripe = OUT_HOST_W'(d + 1);
                stripe_ofs = '0;
            end
            else begin
                stripe_ofs = OUT_OFS_W'(o + 1);
            end
        end
    endfunction

    // Hold the input idle for a span of clocks set by k
    task automatic idle_cycles(input int unsigned k);
        repeat (k) begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
    endtask

    // Hold the input idle until every expected result has arrived
    task automatic drain();
        idle_cycles(1);
        while (expected_routes.size() != 0)
            idle_cycles(1);
    endtask

    // Send one byte, pacing the sender in bursts with random gaps
    task automatic send_byte(input logic [DATA_W-1:0] b, input logic [BLK_W-1:0] blk);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            idle_cycles(gap);
        end
        burst_left--;
        @(negedge clk);
        item_ch.valid        <= 1'b1;
        item_ch.data_byte    <= b;
        item_ch.block_number <= blk;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        route_byte(b, blk);
        items_sent++;
    endtask

    task automatic send_block(input logic [BLK_W-1:0] blk, input int unsigned nbytes);
        repeat (nbytes)
            send_byte(DATA_W'($urandom), blk);
    endtask

    // Write one register once the block has gone idle
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        drain();
        idle_cycles(SETTLE_CYC);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_RAID_LEVEL:  cur_level = val[LEVEL_W-1:0];
            CFG_NUM_HOSTS:   cur_hosts = val[HOST_W-1:0];
            CFG_BLOCK_SIZE:  cur_size  = val[SIZE_W-1:0];
            CFG_BLOCK_COUNT: cur_count = val[COUNT_W-1:0];
            default: ;
        endcase
        restart_block();
        reg_writes++;
    endtask

    task automatic set_layout(input logic [LEVEL_W-1:0] lvl, input int unsigned hosts,
                              input int unsigned size, input int unsigned count);
        write_reg(CFG_RAID_LEVEL, CFG_W'(lvl));
        write_reg(CFG_NUM_HOSTS, CFG_W'(hosts));
        write_reg(CFG_BLOCK_SIZE, CFG_W'(size));
        write_reg(CFG_BLOCK_COUNT, CFG_W'(count));
    endtask

    function automatic logic [BLK_W-1:0] pick_in_range();
        if (cur_count >= BLOCKS_ALL)
            return BLK_W'($urandom);
        return BLK_W'($urandom_range(0, cur_count - 1));
    endfunction

    // Reset values: partial block, block number changed mid-block
    task automatic test_reset_defaults();
        send_byte(8'h00, 24'd0);
        send_byte(8'hFF, BLK_W'(BLK_MAX));
        send_byte(8'h5A, 24'd0);
    endtask

    // Out-of-range block numbers inside a block, then a zero block count
    task automatic test_out_of_range();
        set_layout(LEVEL_FIXED, 3, 3, 1);
        send_byte(8'hFF, 24'd0);
        send_byte(8'h11, 24'd1);
        send_byte(8'h00, 24'd0);
        send_byte(8'h22, BLK_W'(BLK_MAX));
        send_byte(8'hA5, 24'd0);
        write_reg(CFG_BLOCK_COUNT, '0);
        send_byte(8'h33, 24'd0);
    endtask

    // Plain striping, rotating parity on two blocks, and the unused level
    task automatic test_each_level();
        set_layout(LEVEL_STRIPE, 3, 4, BLOCKS_ALL);
        send_block(24'd7, 4);
        set_layout(LEVEL_ROTATE, 3, 2, 25'h1FFFFFF);
        send_block(24'd2, 2);
        send_block(24'd4, 2);
        set_layout(LEVEL_UNUSED, 2, 1, BLOCKS_ALL);
        send_block(24'd9, 1);
    endtask

    // Two hosts with parity: every data byte is its own parity
    task automatic test_two_host_parity();
        set_layout(LEVEL_FIXED, 2, 2, BLOCKS_ALL);
        send_block(24'd3, 2);
    endtask

    // Host count and block size outside their ranges
    task automatic test_clamps();
        set_layout(LEVEL_ROTATE, 15, 8191, BLOCKS_ALL);
        send_block(24'd13, 2);
        set_layout(LEVEL_FIXED, 0, 0, BLOCKS_ALL);
        send_block(24'd1, 2);
    endtask

    // Sender waits for all results mid-block; a register write abandons a block
    task automatic test_pause_and_abandon();
        set_layout(LEVEL_ROTATE, 5, 6, BLOCKS_ALL);
        send_block(24'd21, 3);
        drain();
        send_block(24'd21, 3);
        send_block(24'd22, 2);
        write_reg(CFG_BLOCK_SIZE, CFG_W'(6));
        send_block(24'd23, 6);
    endtask

    // Random layouts, mostly whole blocks with some noise and broken blocks
    task automatic test_random_traffic();
        int unsigned        sel, hosts, size, count, nbytes, phase_items;
        logic [LEVEL_W-1:0] lvl;
        logic [BLK_W-1:0]   blk;
        while (random_items < RANDOM_ITEMS) begin
            lvl   = LEVEL_W'($urandom_range(0, 3));
            hosts = ($urandom_range(0, 4) != 0) ? $urandom_range(2, 8) : $urandom_range(0, 15);
            sel   = $urandom_range(0, 9);
            if (sel < 7)
                size = $urandom_range(1, 24);
            else if (sel == 7)
                size = $urandom_range(25, 96);
            else if (sel == 8)
                size = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(4096, 8191);
            else
                size = $urandom_range(1, 8);
            sel = $urandom_range(0, 9);
            if (sel < 4)
                count = BLOCKS_ALL;
            else if (sel == 4)
                count = 25'h1FFFFFF;
            else
                count = $urandom_range(1, 96);
            set_layout(lvl, hosts, size, count);
            phase_items = 0;
            while (phase_items < 40) begin
                if ($urandom_range(0, 9) < 8) begin
                    blk = pick_in_range();
                    nbytes = clamped_size();
                    if (nbytes > 96)
                        nbytes = $urandom_range(1, 48);
                    repeat (nbytes) begin
                        // Inject an out-of-range byte or move the block number now and then
                        if (cur_count <= BLK_MAX && $urandom_range(0, 11) == 0) begin
                            send_byte(DATA_W'($urandom),
                                      BLK_W'($urandom_range(cur_count, BLK_MAX)));
                            phase_items++;
                        end
                        if ($urandom_range(0, 29) == 0)
                            blk = pick_in_range();
                        send_byte(DATA_W'($urandom), blk);
                        phase_items++;
                    end
                end
                else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_byte(DATA_W'($urandom), BLK_W'($urandom));
                        phase_items++;
                    end
                end
            end
            random_items += phase_items;
        end
    endtask

    // Largest block size: the opening bytes of a full block on two hosts
    task automatic test_full_size_block();
        set_layout(LEVEL_FIXED, 2, BLOCK_BYTES_DEF, BLOCKS_ALL);
        send_block(BLK_W'($urandom), BIG_HEAD);
    endtask

    // Receiver ready pattern, switching between stall modes
    initial begin : result_stall
        int unsigned stall_left, mode, cyc;
        stall_left   = 0;
        mode         = STALL_NONE;
        cyc          = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 96 == 0)
                mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (mode == STALL_LIGHT && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end
            else if (mode == STALL_HEAVY && $urandom_range(0, 9) < 4) begin
                stall_left = $urandom_range(0, 9);
                res_ch.ready <= 1'b0;
            end
            else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic void log_mismatch(input string why, input routed_byte_t want,
                                         input routed_byte_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected host %0d ofs %0d byte %02h par %0b done %0b last %0b st %0b, got host %0d ofs %0d byte %02h par %0b done %0b last %0b st %0b",
                     $realtime, why, want.host, want.ofs, want.data, want.parity, want.done,
                     want.last, want.status, got.host, got.ofs, got.data, got.parity,
                     got.done, got.last, got.status);
    endfunction

    // Compare each result transfer with the oldest expectation
    initial begin : check_results
        routed_byte_t got, want;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) begin
                got.host   = res_ch.host_index;
                got.ofs    = res_ch.stripe_offset;
                got.data   = res_ch.out_byte;
                got.parity = res_ch.is_parity;
                got.done   = res_ch.block_done;
                got.last   = res_ch.last_of_item;
                got.status = res_ch.status;
                results_seen++;
                if (expected_routes.size() == 0) begin
                    log_mismatch("unexpected result", '0, got);
                end
                else begin
                    want = expected_routes.pop_front();
                    if (got.host !== want.host || got.ofs !== want.ofs
                        || got.data !== want.data || got.parity !== want.parity
                        || got.done !== want.done || got.last !== want.last
                        || got.status !== want.status)
                        log_mismatch("mismatch", want, got);
                end
            end
        end
    end

    // Main sequence
    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_RAID_LEVEL;
        cfg_data             = '0;
        item_ch.valid        = 1'b0;
        item_ch.data_byte    = '0;
        item_ch.block_number = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_out_of_range();
        test_each_level();
        test_two_host_parity();
        test_clamps();
        test_pause_and_abandon();
        test_random_traffic();
        test_full_size_block();

        drain();
        idle_cycles(TAIL_CYC);
        $display("Covered %0d input transfers (%0d random) and %0d results", items_sent,
                 random_items, results_seen);
        $display("across %0d register writes over all layouts, clamps and range errors",
                 reg_writes);
        if (mismatch_count == 0 && expected_routes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== raid_stripe_parity_writer.f =====
design/rspw_pkg.sv
design/rspw_item_if.sv
design/rspw_result_if.sv
design/rspw_ram.sv
design/rspw_div.sv
design/rspw_front.sv
design/rspw_queue.sv
design/rspw_back.sv
design/raid_stripe_parity_writer.sv
sim/raid_stripe_parity_writer_test.sv
